// ===== rtl/memory_timing_register_file_wp_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the memory timing register file
// Clocked assertion helpers, removed as a whole when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MEMORY_TIMING_REGISTER_FILE_WP_MACROS_SVH
`define MEMORY_TIMING_REGISTER_FILE_WP_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at every rising edge, suspended while reset is asserted.
`define MTRF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Property checked at every rising edge, also during reset.
`define MTRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MTRF_ASSERT(lbl, clk, rstn, prop, msg)
`define MTRF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/mtrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mtrf_pkg
// Types, register offsets, masks and reset values of the timing register file.
// ----------------------------------------------------------------------------
`default_nettype none

package mtrf_pkg;

  // Number of chip selects, each owning four timing words.
  localparam int ChipSelects = 6;
  localparam int CsW = (ChipSelects > 1) ? $clog2(ChipSelects) : 1;
  localparam int TimingEnd = ChipSelects * 16;

  // Access kinds.
  localparam logic ModeRead  = 1'b0;
  localparam logic ModeWrite = 1'b1;

  // Timing word select within a chip select.
  localparam logic [1:0] WordSetup = 2'd0;
  localparam logic [1:0] WordPulse = 2'd1;
  localparam logic [1:0] WordCycle = 2'd2;
  localparam logic [1:0] WordMode  = 2'd3;

  // Fixed register offsets.
  localparam logic [7:0] OffScramble = 8'h80;
  localparam logic [7:0] OffKeyA     = 8'h84;
  localparam logic [7:0] OffKeyB     = 8'h88;
  localparam logic [7:0] OffIrqEn    = 8'h90;
  localparam logic [7:0] OffProtMode = 8'he4;
  localparam logic [7:0] OffProtStat = 8'he8;

  // Write masks.
  localparam logic [31:0] MaskSetup    = 32'h3f3f3f3f;
  localparam logic [31:0] MaskPulse    = 32'h7f7f7f7f;
  localparam logic [31:0] MaskCycle    = 32'h01ff01ff;
  localparam logic [31:0] MaskMode     = 32'h311f3133;
  localparam logic [31:0] MaskScramble = 32'h00000711;
  localparam logic [31:0] ProtKey      = 32'h534d4300;
  localparam logic [31:0] ProtKeyMask  = 32'hffffff00;

  // Reset values of the timing words.
  localparam logic [31:0] RstSetup = 32'h01010101;
  localparam logic [31:0] RstPulse = 32'h01010101;
  localparam logic [31:0] RstCycle = 32'h00030003;
  localparam logic [31:0] RstMode  = 32'h10001000;

  // Stored widths.
  localparam int SetupW    = 30;
  localparam int PulseW    = 31;
  localparam int CycleW    = 25;
  localparam int ModeW     = 30;
  localparam int ScrambleW = 11;
  localparam int StatusW   = 26;

  // Protect status layout.
  localparam int StViol    = 0;
  localparam int StSeq     = 2;
  localparam int StSwe     = 3;
  localparam int StSrcLo   = 8;
  localparam int StTypeLo  = 24;

  // Software error types.
  localparam logic [1:0] ErrKeyRead  = 2'd0;
  localparam logic [1:0] ErrReadOnly = 2'd1;
  localparam logic [1:0] ErrUndef    = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [7:0]  byte_offset;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/mtrf_regs.sv =====
// ----------------------------------------------------------------------------
// mtrf_regs
// Register storage with access decode, write protection and status logging.
// ----------------------------------------------------------------------------
`default_nettype none

`include "memory_timing_register_file_wp_macros.svh"

module mtrf_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  input  wire mtrf_pkg::req_t req_i,
  output mtrf_pkg::rsp_t     rsp_o
);

  logic [mtrf_pkg::SetupW-1:0] setup_q [mtrf_pkg::ChipSelects];
  logic [mtrf_pkg::PulseW-1:0] pulse_q [mtrf_pkg::ChipSelects];
  logic [mtrf_pkg::CycleW-1:0] cycle_q [mtrf_pkg::ChipSelects];
  logic [mtrf_pkg::ModeW-1:0]  bmode_q [mtrf_pkg::ChipSelects];

  logic [mtrf_pkg::ScrambleW-1:0] scramble_q, scramble_d;
  logic                           irq_en_q, irq_en_d;
  logic                           prot_en_q, prot_en_d;
  logic [mtrf_pkg::StatusW-1:0]   status_q, status_d;

  logic                       is_timing;
  logic [mtrf_pkg::CsW-1:0]   cs;
  logic [1:0]                 word;
  logic                       timing_we;
  logic [31:0]                rdata;
  logic                       blocked;
  logic                       sw_err;
  logic [1:0]                 sw_type;

  assign is_timing = ({1'b0, req_i.byte_offset} < 9'(mtrf_pkg::TimingEnd));
  assign cs        = req_i.byte_offset[4 +: mtrf_pkg::CsW];
  assign word      = req_i.byte_offset[3:2];

  always_comb begin
    scramble_d = scramble_q;
    irq_en_d   = irq_en_q;
    prot_en_d  = prot_en_q;
    status_d   = status_q;
    rdata      = '0;
    timing_we  = 1'b0;
    blocked    = 1'b0;
    sw_err     = 1'b0;
    sw_type    = mtrf_pkg::ErrUndef;

    if (req_valid_i) begin
      if (is_timing) begin
        if (req_i.mode == mtrf_pkg::ModeRead) begin
          case (word)
            mtrf_pkg::WordSetup: rdata = 32'(setup_q[cs]);
            mtrf_pkg::WordPulse: rdata = 32'(pulse_q[cs]);
            mtrf_pkg::WordCycle: rdata = 32'(cycle_q[cs]);
            default:             rdata = 32'(bmode_q[cs]);
          endcase
        end else if (prot_en_q) begin
          blocked = 1'b1;
        end else begin
          timing_we = 1'b1;
        end
      end else if (req_i.mode == mtrf_pkg::ModeRead) begin
        case (req_i.byte_offset)
          mtrf_pkg::OffScramble: rdata = 32'(scramble_q);
          mtrf_pkg::OffKeyA,
          mtrf_pkg::OffKeyB: begin
            sw_err  = 1'b1;
            sw_type = mtrf_pkg::ErrKeyRead;
          end
          mtrf_pkg::OffIrqEn:    rdata = 32'(irq_en_q);
          mtrf_pkg::OffProtMode: rdata = 32'(prot_en_q);
          mtrf_pkg::OffProtStat: begin
            rdata    = 32'(status_q);
            status_d = '0;
          end
          default: sw_err = 1'b1;
        endcase
      end else begin
        case (req_i.byte_offset)
          mtrf_pkg::OffScramble: begin
            scramble_d = req_i.write_data[mtrf_pkg::ScrambleW-1:0]
                       & mtrf_pkg::MaskScramble[mtrf_pkg::ScrambleW-1:0];
          end
          mtrf_pkg::OffKeyA,
          mtrf_pkg::OffKeyB: begin
            // Key storage is write-only and has no visible effect.
          end
          mtrf_pkg::OffIrqEn: begin
            if (prot_en_q) begin
              blocked = 1'b1;
            end else begin
              irq_en_d = req_i.write_data[0];
            end
          end
          mtrf_pkg::OffProtMode: begin
            if ((req_i.write_data & mtrf_pkg::ProtKeyMask) == mtrf_pkg::ProtKey) begin
              prot_en_d = req_i.write_data[0];
            end
          end
          mtrf_pkg::OffProtStat: begin
            sw_err  = 1'b1;
            sw_type = mtrf_pkg::ErrReadOnly;
          end
          default: sw_err = 1'b1;
        endcase
      end

      // The first violation keeps its source offset until status is read.
      if (blocked && !status_q[mtrf_pkg::StViol]) begin
        status_d[mtrf_pkg::StViol]            = 1'b1;
        status_d[mtrf_pkg::StSrcLo +: 16]     = {8'h00, req_i.byte_offset};
      end
      if (sw_err) begin
        if (!status_q[mtrf_pkg::StViol]) begin
          status_d[mtrf_pkg::StSrcLo +: 16] = {8'h00, req_i.byte_offset};
        end
        status_d[mtrf_pkg::StTypeLo +: 2] = sw_type;
        status_d[mtrf_pkg::StSwe]         = 1'b1;
      end
    end
  end

  assign rsp_o.read_data = rdata;
  assign rsp_o.irq_level = irq_en_d & (status_d[mtrf_pkg::StViol] | status_d[mtrf_pkg::StSeq]
                                      | status_d[mtrf_pkg::StSwe]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mtrf_pkg::ChipSelects; i++) begin
        setup_q[i] <= mtrf_pkg::RstSetup[mtrf_pkg::SetupW-1:0];
        pulse_q[i] <= mtrf_pkg::RstPulse[mtrf_pkg::PulseW-1:0];
        cycle_q[i] <= mtrf_pkg::RstCycle[mtrf_pkg::CycleW-1:0];
        bmode_q[i] <= mtrf_pkg::RstMode[mtrf_pkg::ModeW-1:0];
      end
      scramble_q <= '0;
      irq_en_q   <= 1'b0;
      prot_en_q  <= 1'b0;
      status_q   <= '0;
    end else begin
      if (timing_we) begin
        case (word)
          mtrf_pkg::WordSetup: setup_q[cs] <= req_i.write_data[mtrf_pkg::SetupW-1:0]
                                & mtrf_pkg::MaskSetup[mtrf_pkg::SetupW-1:0];
          mtrf_pkg::WordPulse: pulse_q[cs] <= req_i.write_data[mtrf_pkg::PulseW-1:0]
                                & mtrf_pkg::MaskPulse[mtrf_pkg::PulseW-1:0];
          mtrf_pkg::WordCycle: cycle_q[cs] <= req_i.write_data[mtrf_pkg::CycleW-1:0]
                                & mtrf_pkg::MaskCycle[mtrf_pkg::CycleW-1:0];
          default:             bmode_q[cs] <= req_i.write_data[mtrf_pkg::ModeW-1:0]
                                & mtrf_pkg::MaskMode[mtrf_pkg::ModeW-1:0];
        endcase
      end
      scramble_q <= scramble_d;
      irq_en_q   <= irq_en_d;
      prot_en_q  <= prot_en_d;
      status_q   <= status_d;
    end
  end

  `MTRF_ASSERT(a_stat_read_clears, clk_i, rst_ni, (req_valid_i && req_i.mode == mtrf_pkg::ModeRead && req_i.byte_offset == mtrf_pkg::OffProtStat) |=> (status_q == '0), "status not cleared by read")
  `MTRF_ASSERT(a_seq_bit_zero, clk_i, rst_ni, !status_q[mtrf_pkg::StSeq], "sequence error bit set")
  `MTRF_ASSERT(a_irq_en_protected, clk_i, rst_ni, (req_valid_i && req_i.mode == mtrf_pkg::ModeWrite && req_i.byte_offset == mtrf_pkg::OffIrqEn && prot_en_q) |=> $stable(irq_en_q), "protected interrupt enable changed")
  `MTRF_ASSERT(a_viol_src_sticky, clk_i, rst_ni, (status_q[mtrf_pkg::StViol] && !(req_valid_i && req_i.mode == mtrf_pkg::ModeRead && req_i.byte_offset == mtrf_pkg::OffProtStat)) |=> $stable(status_q[23:8]), "violation source overwritten")

endmodule

`default_nettype wire

// ===== rtl/memory_timing_register_file_wp.sv =====
// ----------------------------------------------------------------------------
// memory_timing_register_file_wp
// Register block of a static memory controller with keyed write protection.
// ----------------------------------------------------------------------------
// One bus request is taken at each rising edge where start is high and busy
// is low, and the block can take a new request in every cycle, so a stream of
// back-to-back accesses runs at one request per clock. Each request produces
// exactly one response, shown on rsp_o for a single cycle with rsp_valid_o
// high, after the request was taken: the request is captured in an
// input register, decoded and applied to the register state in the next
// cycle, and the response is captured in an output register. The receiver
// cannot stall the response, so it must take it in the cycle it appears.
// Busy is set by reset and cleared by the clock once reset is released; after that
// it stays low. Requests are applied strictly in order, so a read that
// follows a write sees the written value. Reading the protect status word
// returns it and clears it; the irq_level of every response is the interrupt enable
// ANDed with the OR of the violation, sequence and software error flags after the access.
// ----------------------------------------------------------------------------
`default_nettype none

`include "memory_timing_register_file_wp_macros.svh"

module memory_timing_register_file_wp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire mtrf_pkg::req_t req_i,
  output logic                rsp_valid_o,
  output mtrf_pkg::rsp_t      rsp_o
);

  // Busy holds off requests only while the block comes out of reset.
  logic busy_q;

  // Input stage: the request being decoded in this cycle.
  logic           req_valid_q, req_valid_d;
  mtrf_pkg::req_t req_q;

  // Output stage: the response shown to the receiver.
  logic           rsp_valid_q;
  mtrf_pkg::rsp_t rsp_q, rsp_d;

  assign req_valid_d = start & ~busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      busy_q      <= 1'b0;
      req_valid_q <= req_valid_d;
      rsp_valid_q <= req_valid_q;
    end
  end

  // Payload registers need no reset; the valid flags qualify them.
  always_ff @(posedge clk_i) begin
    if (req_valid_d) begin
      req_q <= req_i;
    end
    if (req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  // The register file applies the request and forms its response in the
  // same cycle, so the state seen by the next request is already updated.
  mtrf_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_q),
    .req_i       (req_q),
    .rsp_o       (rsp_d)
  );

  assign busy        = busy_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  `MTRF_ASSERT(a_rsp_follows_req, clk_i, rst_ni, (start && !busy) |=> ##1 rsp_valid_o, "response missing two cycles after request")
  `MTRF_ASSERT(a_rsp_has_req, clk_i, rst_ni, rsp_valid_o |-> $past(start && !busy, 2), "response without request")
  `MTRF_ASSERT(a_no_rsp_while_busy, clk_i, rst_ni, busy |-> !rsp_valid_o, "response while coming out of reset")

endmodule

`default_nettype wire

// ===== tb/tb_memory_timing_register_file_wp.sv =====
// ----------------------------------------------------------------------------
// tb_memory_timing_register_file_wp
// Self-checking bench for the memory timing register file with write protect.
// Bus requests come from a pending queue and are driven by a clocked driver
// with random sender gaps. Every accepted request is run through a local
// model of the register file, and the response it should produce is queued.
// A clocked monitor takes each response strobe and compares it field by field
// with the oldest queued response.
// ----------------------------------------------------------------------------
module tb_memory_timing_register_file_wp;

  localparam int ClkPeriod     = 20;
  localparam int ResetCycles   = 5;
  localparam int RandomCount   = 1200;
  localparam int DrainCycles   = 8;
  localparam int TimeoutCycles = 200000;

  // Highest byte of the window; nothing is mapped there.
  localparam logic [7:0] OffLastByte = 8'hff;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Driven request and its strobe. Both hold known values from time zero.
  logic start = 1'b0;
  mtrf_pkg::req_t req_q = '0;

  logic busy;
  logic rsp_valid_o;
  mtrf_pkg::rsp_t rsp_o;

  memory_timing_register_file_wp u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_q),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  always begin
    #(ClkPeriod / 2) clk_i = 1'b1;
    #(ClkPeriod / 2) clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local copy of the register state, as it should be after every request the
  // block has taken so far.
  // --------------------------------------------------------------------------
  logic [31:0] setup_words [mtrf_pkg::ChipSelects];
  logic [31:0] pulse_words [mtrf_pkg::ChipSelects];
  logic [31:0] cycle_words [mtrf_pkg::ChipSelects];
  logic [31:0] mode_words  [mtrf_pkg::ChipSelects];
  logic [31:0] scramble_word;
  logic        irq_en;
  logic        prot_en;
  logic [31:0] prot_status;

  // Requests still to be driven, and responses the block still owes.
  mtrf_pkg::req_t bus_access_q [$];
  mtrf_pkg::rsp_t owed_rsp_q [$];

  int  total_requests = 0;
  int  issued_cnt = 0;
  int  accepted_cnt = 0;
  bit  mismatch_seen = 1'b0;

  // A software error always updates the type and sets its flag. The source
  // offset is only overwritten while no protect violation is on record, so
  // the first violation keeps pointing at the offending register.
  function automatic void log_sw_error(input logic [7:0] off, input logic [1:0] kind);
    if (!prot_status[mtrf_pkg::StViol]) begin
      prot_status[mtrf_pkg::StTypeLo-1:mtrf_pkg::StSrcLo] = {8'h00, off};
    end
    prot_status[mtrf_pkg::StTypeLo+1:mtrf_pkg::StTypeLo] = kind;
    prot_status[mtrf_pkg::StSwe] = 1'b1;
  endfunction

  // Returns 1 when a write must be dropped. The first dropped write records
  // the violation flag and its offset.
  function automatic bit write_blocked(input logic [7:0] off);
    if (!prot_en) begin
      return 1'b0;
    end
    if (!prot_status[mtrf_pkg::StViol]) begin
      prot_status[mtrf_pkg::StTypeLo-1:mtrf_pkg::StSrcLo] = {8'h00, off};
      prot_status[mtrf_pkg::StViol] = 1'b1;
    end
    return 1'b1;
  endfunction

  // Applies one bus access to the local register state and returns the
  // response the block should give for it.
  function automatic mtrf_pkg::rsp_t apply_bus_access(input mtrf_pkg::req_t acc);
    mtrf_pkg::rsp_t rsp;
    logic [7:0]     off;
    logic [31:0]    data;
    logic [1:0]     word;
    int             cs;
    off  = acc.byte_offset;
    data = acc.write_data;
    word = off[3:2];
    cs   = int'(off[7:4]);
    rsp  = '0;
    if (int'(off) < mtrf_pkg::TimingEnd) begin
      // Timing words alias within each 4-byte slot: the low two bits are
      // simply ignored.
      if (acc.mode == mtrf_pkg::ModeRead) begin
        case (word)
          mtrf_pkg::WordSetup: rsp.read_data = setup_words[cs];
          mtrf_pkg::WordPulse: rsp.read_data = pulse_words[cs];
          mtrf_pkg::WordCycle: rsp.read_data = cycle_words[cs];
          default:             rsp.read_data = mode_words[cs];
        endcase
      end else if (!write_blocked(off)) begin
        case (word)
          mtrf_pkg::WordSetup: setup_words[cs] = data & mtrf_pkg::MaskSetup;
          mtrf_pkg::WordPulse: pulse_words[cs] = data & mtrf_pkg::MaskPulse;
          mtrf_pkg::WordCycle: cycle_words[cs] = data & mtrf_pkg::MaskCycle;
          default:             mode_words[cs]  = data & mtrf_pkg::MaskMode;
        endcase
      end
    end else if (acc.mode == mtrf_pkg::ModeRead) begin
      case (off)
        mtrf_pkg::OffScramble: rsp.read_data = scramble_word;
        mtrf_pkg::OffKeyA, mtrf_pkg::OffKeyB: log_sw_error(off, mtrf_pkg::ErrKeyRead);
        mtrf_pkg::OffIrqEn: rsp.read_data = {31'd0, irq_en};
        mtrf_pkg::OffProtMode: rsp.read_data = {31'd0, prot_en};
        mtrf_pkg::OffProtStat: begin
          rsp.read_data = prot_status;
          prot_status = '0;
        end
        default: log_sw_error(off, mtrf_pkg::ErrUndef);
      endcase
    end else begin
      case (off)
        mtrf_pkg::OffScramble: scramble_word = data & mtrf_pkg::MaskScramble;
        mtrf_pkg::OffKeyA, mtrf_pkg::OffKeyB: ;
        mtrf_pkg::OffIrqEn: begin
          if (!write_blocked(off)) begin
            irq_en = data[0];
          end
        end
        mtrf_pkg::OffProtMode: begin
          if ((data & mtrf_pkg::ProtKeyMask) == mtrf_pkg::ProtKey) begin
            prot_en = data[0];
          end
        end
        mtrf_pkg::OffProtStat: log_sw_error(off, mtrf_pkg::ErrReadOnly);
        default: log_sw_error(off, mtrf_pkg::ErrUndef);
      endcase
    end
    // The sequence error flag is never raised, but it still counts toward
    // the interrupt line.
    rsp.irq_level = irq_en &
                    (prot_status[mtrf_pkg::StViol] | prot_status[mtrf_pkg::StSeq]
                     | prot_status[mtrf_pkg::StSwe]);
    return rsp;
  endfunction

  task automatic queue_access(input logic mode, input logic [7:0] off,
                              input logic [31:0] data);
    mtrf_pkg::req_t acc;
    acc.mode        = mode;
    acc.byte_offset = off;
    acc.write_data  = data;
    bus_access_q.push_back(acc);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus. A directed opening walks through the reset values, the write
  // masks, aliasing, every fixed register, the key check and the protection
  // flow. The random part then mixes timing-word traffic with accesses to the
  // fixed registers, keyed protect-mode writes and some fully random offsets.
  // --------------------------------------------------------------------------
  initial begin
    int          pick;
    logic        mode;
    logic [7:0]  off;
    logic [31:0] data;

    for (int i = 0; i < mtrf_pkg::ChipSelects; i++) begin
      setup_words[i] = mtrf_pkg::RstSetup;
      pulse_words[i] = mtrf_pkg::RstPulse;
      cycle_words[i] = mtrf_pkg::RstCycle;
      mode_words[i]  = mtrf_pkg::RstMode;
    end
    scramble_word = '0;
    irq_en        = 1'b0;
    prot_en       = 1'b0;
    prot_status   = '0;

    // Reset values at both ends of the timing area, and an unaligned alias.
    queue_access(mtrf_pkg::ModeRead, 8'h00, '0);
    queue_access(mtrf_pkg::ModeRead, 8'(mtrf_pkg::TimingEnd - 4), '0);
    queue_access(mtrf_pkg::ModeRead, 8'h07, 32'hffffffff);
    // Masked writes with all ones, read back, and a write of all zeros.
    queue_access(mtrf_pkg::ModeWrite, 8'h00, 32'hffffffff);
    queue_access(mtrf_pkg::ModeRead, 8'h00, '0);
    queue_access(mtrf_pkg::ModeWrite, 8'(mtrf_pkg::TimingEnd - 1), 32'hffffffff);
    queue_access(mtrf_pkg::ModeRead, 8'(mtrf_pkg::TimingEnd - 4), '0);
    queue_access(mtrf_pkg::ModeWrite, 8'h18, 32'h00000000);
    queue_access(mtrf_pkg::ModeWrite, mtrf_pkg::OffScramble, 32'hffffffff);
    queue_access(mtrf_pkg::ModeRead, mtrf_pkg::OffScramble, '0);
    // Key reads raise a software error, key writes do nothing.
    queue_access(mtrf_pkg::ModeWrite, mtrf_pkg::OffKeyB, 32'hffffffff);
    queue_access(mtrf_pkg::ModeRead, mtrf_pkg::OffKeyA, '0);
    // With the interrupt enabled, the pending error shows on the line until
    // the status word is read and cleared.
    queue_access(mtrf_pkg::ModeWrite, mtrf_pkg::OffIrqEn, 32'hffffffff);
    queue_access(mtrf_pkg::ModeRead, mtrf_pkg::OffIrqEn, '0);
    queue_access(mtrf_pkg::ModeRead, OffLastByte, '0);
    queue_access(mtrf_pkg::ModeRead, mtrf_pkg::OffProtStat, '0);
    queue_access(mtrf_pkg::ModeWrite, mtrf_pkg::OffProtStat, 32'hffffffff);
    queue_access(mtrf_pkg::ModeWrite, 8'(mtrf_pkg::TimingEnd), 32'h12345678);
    // A wrong key is ignored; the right key turns protection on.
    queue_access(mtrf_pkg::ModeWrite, mtrf_pkg::OffProtMode, 32'h534d4201);
    queue_access(mtrf_pkg::ModeWrite, mtrf_pkg::OffProtMode, mtrf_pkg::ProtKey | 32'h1);
    queue_access(mtrf_pkg::ModeRead, mtrf_pkg::OffProtMode, '0);
    // Protected writes are dropped and the first one is recorded. Scramble
    // control stays writable. A later software error keeps the source offset.
    queue_access(mtrf_pkg::ModeWrite, 8'h10, 32'hffffffff);
    queue_access(mtrf_pkg::ModeWrite, mtrf_pkg::OffIrqEn, 32'h0);
    queue_access(mtrf_pkg::ModeWrite, mtrf_pkg::OffScramble, 32'h0);
    queue_access(mtrf_pkg::ModeRead, mtrf_pkg::OffKeyB, '0);
    queue_access(mtrf_pkg::ModeRead, mtrf_pkg::OffProtStat, '0);
    queue_access(mtrf_pkg::ModeWrite, mtrf_pkg::OffProtMode, mtrf_pkg::ProtKey);

    for (int n = 0; n < RandomCount; n++) begin
      mode = 1'($urandom_range(1));
      data = $urandom;
      pick = $urandom_range(99);
      if (pick < 55) begin
        off = 8'($urandom_range(mtrf_pkg::TimingEnd - 1));
      end else if (pick < 85) begin
        case ($urandom_range(5))
          0: off = mtrf_pkg::OffScramble;
          1: off = mtrf_pkg::OffKeyA;
          2: off = mtrf_pkg::OffKeyB;
          3: off = mtrf_pkg::OffIrqEn;
          4: off = mtrf_pkg::OffProtMode;
          default: off = mtrf_pkg::OffProtStat;
        endcase
      end else begin
        off = 8'($urandom_range(255));
      end
      // Most protect-mode writes carry the key so that protection toggles.
      if (off == mtrf_pkg::OffProtMode && $urandom_range(3) != 0) begin
        data = (mtrf_pkg::ProtKey & mtrf_pkg::ProtKeyMask)
             | (data & ~mtrf_pkg::ProtKeyMask);
      end
      queue_access(mode, off, data);
    end
    total_requests = bus_access_q.size();

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every request was taken and every response checked, then
    // leave the block a drain period to show any stray response.
    while (accepted_cnt < total_requests || owed_rsp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (!mismatch_seen) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver. A request counts as taken at an edge where start is high and busy
  // is low; its response is predicted right there. The next request is then
  // presented, or start is dropped for a random gap. The gap rate follows the
  // progress through the stream: 28 percent, then 74 percent, then none.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_proc
    int idle_pct;
    if (issued_cnt < total_requests / 3) begin
      idle_pct = 28;
    end else if (issued_cnt < 2 * total_requests / 3) begin
      idle_pct = 74;
    end else begin
      idle_pct = 0;
    end
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        owed_rsp_q.push_back(apply_bus_access(req_q));
        accepted_cnt++;
      end
      if (bus_access_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        req_q <= bus_access_q.pop_front();
        start <= 1'b1;
        issued_cnt++;
      end else begin
        start <= 1'b0;
      end
    end
    // While busy holds the request off, start and the request simply stay.
  end

  // --------------------------------------------------------------------------
  // Monitor. Every response strobe is matched against the oldest owed
  // response; the receiver never stalls, so each strobe is one response.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_proc
    mtrf_pkg::rsp_t owed;
    if (rst_ni && rsp_valid_o) begin
      if (owed_rsp_q.size() == 0) begin
        $display("%0t: unexpected response, expected none actual read_data %08h irq %0b",
                 $time, rsp_o.read_data, rsp_o.irq_level);
        mismatch_seen = 1'b1;
      end else begin
        owed = owed_rsp_q.pop_front();
        if (rsp_o.read_data !== owed.read_data) begin
          $display("%0t: read_data mismatch, expected %08h actual %08h",
                   $time, owed.read_data, rsp_o.read_data);
          mismatch_seen = 1'b1;
        end
        if (rsp_o.irq_level !== owed.irq_level) begin
          $display("%0t: irq_level mismatch, expected %0b actual %0b",
                   $time, owed.irq_level, rsp_o.irq_level);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a missing response ends the run here.
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
